### sv/euler_view_matrix_assert.svh
// assertion macros used by the checker file
// depends on nothing
`ifndef EULER_VIEW_MATRIX_ASSERT_SVH
`define EULER_VIEW_MATRIX_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define EVM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define EVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/evm_pkg.sv
// types and constants of the euler view matrix block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package evm_pkg;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] roll_angle;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } t_out;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0: atan_q30 = 34'sd843314856;
            5'd1: atan_q30 = 34'sd497837829;
            5'd2: atan_q30 = 34'sd263043836;
            5'd3: atan_q30 = 34'sd133525158;
            5'd4: atan_q30 = 34'sd67021686;
            5'd5: atan_q30 = 34'sd33543515;
            5'd6: atan_q30 = 34'sd16775850;
            5'd7: atan_q30 = 34'sd8388437;
            5'd8: atan_q30 = 34'sd4194282;
            5'd9: atan_q30 = 34'sd2097149;
            5'd10: atan_q30 = 34'sd1048575;
            5'd11: atan_q30 = 34'sd524287;
            5'd12: atan_q30 = 34'sd262143;
            5'd13: atan_q30 = 34'sd131071;
            5'd14: atan_q30 = 34'sd65535;
            5'd15: atan_q30 = 34'sd32767;
            5'd16: atan_q30 = 34'sd16383;
            5'd17: atan_q30 = 34'sd8191;
            5'd18: atan_q30 = 34'sd4095;
            5'd19: atan_q30 = 34'sd2047;
            5'd20: atan_q30 = 34'sd1023;
            5'd21: atan_q30 = 34'sd511;
            5'd22: atan_q30 = 34'sd255;
            5'd23: atan_q30 = 34'sd127;
            default: atan_q30 = 34'sd0;
        endcase
    endfunction

    // round a q60 value to q1.14 and clamp to unit
    function automatic logic signed [15:0] to_q14(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< 45)) >>> 46;
        if (t > 64'sd16384) to_q14 = UNIT_Q14;
        else if (t < -64'sd16384) to_q14 = -UNIT_Q14;
        else to_q14 = t[15:0];
    endfunction
endpackage
`default_nettype wire

### sv/evm_cordic.sv
// pipelined cordic sine and cosine, one rotation per stage
// depends on evm_pkg
`timescale 1ns / 1ps
`default_nettype none
module evm_cordic #(
    parameter int ITER = 16
) (
    input  wire               i_clk,
    input  wire               i_en,
    input  wire signed [15:0] i_angle,
    output logic signed [33:0] o_sin,
    output logic signed [33:0] o_cos
);
    logic signed [33:0] r_x [ITER+1];
    logic signed [33:0] r_y [ITER+1];
    logic signed [33:0] r_z [ITER+1];
    logic               r_f [ITER+1];
    logic signed [33:0] n_a;

    always_comb begin
        n_a = 34'(i_angle) <<< 17;
    end

    // range reduction stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= evm_pkg::CORDIC_GAIN;
            r_y[0] <= '0;
            if (n_a > evm_pkg::HALF_PI_Q30) begin
                r_z[0] <= n_a - evm_pkg::PI_Q30;
                r_f[0] <= 1'b1;
            end else if (n_a < -evm_pkg::HALF_PI_Q30) begin
                r_z[0] <= n_a + evm_pkg::PI_Q30;
                r_f[0] <= 1'b1;
            end else begin
                r_z[0] <= n_a;
                r_f[0] <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < ITER; g++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[g+1] <= r_f[g];
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - evm_pkg::atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + evm_pkg::atan_q30(5'(g));
                end
            end
        end
    end

    assign o_sin = r_f[ITER] ? -r_y[ITER] : r_y[ITER];
    assign o_cos = r_f[ITER] ? -r_x[ITER] : r_x[ITER];
endmodule
`default_nettype wire

### sv/euler_view_matrix.sv
// euler angle view matrix: pose in, rotation and translation out
// uses the per-channel trig pipeline, the 3x4 view matrix
//
// Usage: i_in_valid/o_in_ready carry a pose request (angles Q3.13,
// position Q16.16); o_out_valid/i_out_ready carry the 3x4 view matrix
// (rotation Q1.14 clamped to unit, translation Q16.16 saturated).
// Throughput: one pose per cycle while the output is not stalled.
// o_out_valid rises once a pose has passed the cordic chain (range
// reduction plus one rotation per stage) followed by six product and
// sum stages.
// The whole pipeline advances together; when the receiver holds
// i_out_ready low with a result waiting, every stage freezes and
// o_in_ready drops, so nothing is lost or repeated. An empty slot inside
// the pipeline moves only when the whole pipeline moves.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module euler_view_matrix #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  evm_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output evm_pkg::t_out  o_out_data
);
    localparam int ITER = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;
    localparam int CDEPTH = ITER + 1;
    localparam int DEPTH = CDEPTH + 6;

    logic                r_v [DEPTH];
    logic                en;
    logic signed [31:0]  r_px [CDEPTH];
    logic signed [31:0]  r_py [CDEPTH];
    logic signed [31:0]  r_pz [CDEPTH];
    logic signed [33:0]  sp, cp, sy, cy, sr, cr;

    assign en = !r_v[DEPTH-1] || i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_v[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_in_valid;
            for (int k = 1; k < DEPTH; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px[0] <= i_in_data.pos_x;
            r_py[0] <= i_in_data.pos_y;
            r_pz[0] <= i_in_data.pos_z;
            for (int k = 1; k < CDEPTH; k++) begin
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
                r_pz[k] <= r_pz[k-1];
            end
        end
    end

    evm_cordic #(.ITER(ITER)) u_pitch (.i_clk(i_clk), .i_en(en),
        .i_angle(i_in_data.pitch_angle), .o_sin(sp), .o_cos(cp));
    evm_cordic #(.ITER(ITER)) u_yaw (.i_clk(i_clk), .i_en(en),
        .i_angle(i_in_data.yaw_angle), .o_sin(sy), .o_cos(cy));
    evm_cordic #(.ITER(ITER)) u_roll (.i_clk(i_clk), .i_en(en),
        .i_angle(i_in_data.roll_angle), .o_sin(sr), .o_cos(cr));

    // stage a: pair products
    logic signed [63:0] r_a_cycr, r_a_cysr, r_a_sycr, r_a_sysr, r_a_spsy, r_a_cpsy;
    logic signed [63:0] r_a_cpsr, r_a_cpcr, r_a_spsr, r_a_spcr, r_a_spcy, r_a_cpcy;
    logic signed [63:0] r_a_sy;
    logic signed [33:0] r_a_cr, r_a_sr;
    logic signed [31:0] r_a_px, r_a_py, r_a_pz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_cycr <= 64'(cy) * 64'(cr);
            r_a_cysr <= 64'(cy) * 64'(sr);
            r_a_sy   <= -(64'(sy) <<< 30);
            r_a_spsy <= 64'(sp) * 64'(sy);
            r_a_cpsy <= 64'(cp) * 64'(sy);
            r_a_cpsr <= 64'(cp) * 64'(sr);
            r_a_cpcr <= 64'(cp) * 64'(cr);
            r_a_spsr <= 64'(sp) * 64'(sr);
            r_a_spcr <= 64'(sp) * 64'(cr);
            r_a_spcy <= 64'(sp) * 64'(cy);
            r_a_cpcy <= 64'(cp) * 64'(cy);
            r_a_sycr <= '0;
            r_a_sysr <= '0;
            r_a_cr <= cr;
            r_a_sr <= sr;
            r_a_px <= r_px[CDEPTH-1];
            r_a_py <= r_py[CDEPTH-1];
            r_a_pz <= r_pz[CDEPTH-1];
        end
    end

    // stage b: round q60 pairs to q30, multiply by the third factor
    logic signed [63:0] r_b_t10, r_b_t11, r_b_t20, r_b_t21;
    logic signed [63:0] r_b_cycr, r_b_cysr, r_b_sy, r_b_cpsr, r_b_cpcr;
    logic signed [63:0] r_b_spsr, r_b_spcr, r_b_spcy, r_b_cpcy;
    logic signed [31:0] r_b_px, r_b_py, r_b_pz;
    logic signed [33:0] n_spsy, n_cpsy;
    always_comb begin
        n_spsy = 34'((r_a_spsy + (64'sd1 <<< 29)) >>> 30);
        n_cpsy = 34'((r_a_cpsy + (64'sd1 <<< 29)) >>> 30);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_t10 <= 64'(n_spsy) * 64'(r_a_cr);
            r_b_t11 <= 64'(n_spsy) * 64'(r_a_sr);
            r_b_t20 <= 64'(n_cpsy) * 64'(r_a_cr);
            r_b_t21 <= 64'(n_cpsy) * 64'(r_a_sr);
            r_b_cycr <= r_a_cycr;
            r_b_cysr <= r_a_cysr;
            r_b_sy <= r_a_sy + r_a_sycr + r_a_sysr;
            r_b_cpsr <= r_a_cpsr;
            r_b_cpcr <= r_a_cpcr;
            r_b_spsr <= r_a_spsr;
            r_b_spcr <= r_a_spcr;
            r_b_spcy <= r_a_spcy;
            r_b_cpcy <= r_a_cpcy;
            r_b_px <= r_a_px;
            r_b_py <= r_a_py;
            r_b_pz <= r_a_pz;
        end
    end

    // stage c: sums, round and clamp to q1.14
    logic signed [15:0] r_c_r [9];
    logic signed [31:0] r_c_px, r_c_py, r_c_pz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_r[0] <= evm_pkg::to_q14(r_b_cycr);
            r_c_r[1] <= evm_pkg::to_q14(r_b_cysr);
            r_c_r[2] <= evm_pkg::to_q14(r_b_sy);
            r_c_r[3] <= evm_pkg::to_q14(r_b_t10 - r_b_cpsr);
            r_c_r[4] <= evm_pkg::to_q14(r_b_t11 + r_b_cpcr);
            r_c_r[5] <= evm_pkg::to_q14(r_b_spcy);
            r_c_r[6] <= evm_pkg::to_q14(r_b_t20 + r_b_spsr);
            r_c_r[7] <= evm_pkg::to_q14(r_b_t21 - r_b_spcr);
            r_c_r[8] <= evm_pkg::to_q14(r_b_cpcy);
            r_c_px <= r_b_px;
            r_c_py <= r_b_py;
            r_c_pz <= r_b_pz;
        end
    end

    // stage d: position products
    logic signed [47:0] r_d_p [9];
    logic signed [15:0] r_d_r [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_d_p[k]   <= 48'(r_c_r[k])   * 48'(r_c_px);
                r_d_p[k+3] <= 48'(r_c_r[k+3]) * 48'(r_c_py);
                r_d_p[k+6] <= 48'(r_c_r[k+6]) * 48'(r_c_pz);
            end
            r_d_r <= r_c_r;
        end
    end

    // stage e: sum and negate
    logic signed [49:0] r_e_s [3];
    logic signed [15:0] r_e_r [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_e_s[k] <= -(50'(r_d_p[k]) + 50'(r_d_p[k+3]) + 50'(r_d_p[k+6]));
            end
            r_e_r <= r_d_r;
        end
    end

    // stage f: round and saturate to q16.16
    logic signed [35:0] n_t [3];
    logic signed [31:0] r_f_t [3];
    logic signed [15:0] r_f_r [9];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_t[k] = 36'((r_e_s[k] + 50'sd8192) >>> 14);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (n_t[k] > 36'sd2147483647) r_f_t[k] <= 32'sh7fffffff;
                else if (n_t[k] < -36'sd2147483648) r_f_t[k] <= 32'sh80000000;
                else r_f_t[k] <= n_t[k][31:0];
            end
            r_f_r <= r_e_r;
        end
    end

    always_comb begin
        o_out_data.rot_00 = r_f_r[0];
        o_out_data.rot_01 = r_f_r[1];
        o_out_data.rot_02 = r_f_r[2];
        o_out_data.rot_10 = r_f_r[3];
        o_out_data.rot_11 = r_f_r[4];
        o_out_data.rot_12 = r_f_r[5];
        o_out_data.rot_20 = r_f_r[6];
        o_out_data.rot_21 = r_f_r[7];
        o_out_data.rot_22 = r_f_r[8];
        o_out_data.trans_x = r_f_t[0];
        o_out_data.trans_y = r_f_t[1];
        o_out_data.trans_z = r_f_t[2];
    end
endmodule
`default_nettype wire

### sv/evm_checker.sv
// port-level checker for euler_view_matrix, bound to the top level
// depends on evm_pkg and euler_view_matrix_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "euler_view_matrix_assert.svh"
module evm_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           o_in_ready,
    input wire           o_out_valid,
    input wire           i_out_ready,
    input evm_pkg::t_out o_out_data
);
    logic stall;
    logic rot_ok;

    assign stall = o_out_valid && !i_out_ready;
    assign rot_ok = (o_out_data.rot_22 <= 16'sd16384) && (o_out_data.rot_22 >= -16'sd16384);

    `EVM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, o_out_valid)
    `EVM_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, stall, $stable(o_out_data))
    `EVM_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `EVM_ASSERT_IMPL(a_rot_range, i_clk, i_rst_n, o_out_valid, rot_ok)
endmodule

bind euler_view_matrix evm_checker u_evm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);
`default_nettype wire
